### src/min_tracking_stack_macros.svh
// ---------------------------------------------------------------------------
// min_tracking_stack_macros.svh
// Assertion macros used by the checker file of the min tracking stack
// ---------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_MACROS_SVH
`define MIN_TRACKING_STACK_MACROS_SVH

// same-cycle implication, disabled during reset
`define MTS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("min tracking stack assertion failed");

// next-cycle implication, disabled during reset
`define MTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("min tracking stack assertion failed");

`endif

### src/mts_pkg.sv
// ---------------------------------------------------------------------------
// mts_pkg
// Constants, codes and transaction types of the min tracking stack
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

  // stack geometry
  localparam int DEPTH  = 8;
  localparam int DATA_W = 32;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  // request kinds
  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_POP  = 2'd1;
  localparam logic [1:0] KIND_MIN  = 2'd2;

  // response status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RSVD  = 2'd3;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [1:0]               status;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

`default_nettype wire

### src/min_tracking_stack.sv
// Flow: a transaction accepted while idle is latched as the top entries are read from
// the stores; it executes in the exec state and its response is registered on rsp,
// with done high. No new transaction is taken while busy; the store read of the top
// entries happens on accept and the execute step with its store write in the exec state.
// Reset: synchronous rst empties both stores (counts to zero) and clears busy and done.
// ---------------------------------------------------------------------------
// min_tracking_stack
// Bounded LIFO stack of signed values reporting its running minimum
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module min_tracking_stack (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output      logic          busy,
  input  wire mts_pkg::req_t req,
  output      logic          done,
  output      mts_pkg::rsp_t rsp
);

  mts_pkg::cmd_t cmd;

  // sequencer
  mts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // stores and response
  mts_datapath u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

endmodule

`default_nettype wire

### src/mts_ram.sv
// ---------------------------------------------------------------------------
// mts_ram
// Generic single-write, single-read RAM with registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/mts_ctrl.sv
// ---------------------------------------------------------------------------
// mts_ctrl
// Two-state sequencer: fetch the top entries, then execute the transaction
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mts_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output      logic          busy,
  output      mts_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // commands to the datapath
  assign busy     = (state != S_IDLE);
  assign cmd.load = (state == S_IDLE) && start;
  assign cmd.exec = (state == S_EXEC);

endmodule

`default_nettype wire

### src/mts_datapath.sv
// ---------------------------------------------------------------------------
// mts_datapath
// Element and running-minimum stores, their counts and the response register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mts_datapath (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mts_pkg::cmd_t cmd,
  input  wire mts_pkg::req_t req,
  output      logic          done,
  output      mts_pkg::rsp_t rsp
);

  logic [mts_pkg::CNT_W-1:0]  ecount;
  logic [mts_pkg::CNT_W-1:0]  ecount_next;
  logic [mts_pkg::CNT_W-1:0]  mcount;
  logic [mts_pkg::CNT_W-1:0]  mcount_next;
  logic [mts_pkg::CNT_W-1:0]  ecount_dec;
  logic [mts_pkg::CNT_W-1:0]  mcount_dec;
  logic [1:0]                 op_kind;
  logic signed [mts_pkg::DATA_W-1:0] op_value;
  logic signed [mts_pkg::DATA_W-1:0] elem_rd;
  logic signed [mts_pkg::DATA_W-1:0] min_rd;
  logic                       e_we;
  logic                       m_we;
  mts_pkg::rsp_t              rsp_next;

  assign ecount_dec = ecount - 1'b1;
  assign mcount_dec = mcount - 1'b1;

  // latch the request on accept
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_kind  <= req.kind;
      op_value <= req.value;
    end
  end

  // element store, read at the current top
  mts_ram #(
    .WIDTH (mts_pkg::DATA_W),
    .DEPTH (mts_pkg::DEPTH)
  ) u_elem_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (ecount[mts_pkg::ADDR_W-1:0]),
    .wdata (op_value),
    .re    (cmd.load),
    .raddr (ecount_dec[mts_pkg::ADDR_W-1:0]),
    .rdata (elem_rd)
  );

  // running-minimum store, read at the current top
  mts_ram #(
    .WIDTH (mts_pkg::DATA_W),
    .DEPTH (mts_pkg::DEPTH)
  ) u_min_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (mcount[mts_pkg::ADDR_W-1:0]),
    .wdata (op_value),
    .re    (cmd.load),
    .raddr (mcount_dec[mts_pkg::ADDR_W-1:0]),
    .rdata (min_rd)
  );

  // execute the latched transaction against the fetched top entries
  always_comb begin
    e_we        = 1'b0;
    m_we        = 1'b0;
    ecount_next = ecount;
    mcount_next = mcount;
    rsp_next    = '0;
    rsp_next.status = mts_pkg::ST_OK;
    case (op_kind)
      mts_pkg::KIND_PUSH: begin
        if (ecount >= mts_pkg::CNT_FULL) begin
          rsp_next.status = mts_pkg::ST_FULL;
        end else begin
          e_we        = cmd.exec;
          ecount_next = ecount + 1'b1;
          if (mcount == '0) begin
            m_we        = cmd.exec;
            mcount_next = mcount + 1'b1;
          end else if ((mcount < mts_pkg::CNT_FULL) && (op_value <= min_rd)) begin
            m_we        = cmd.exec;
            mcount_next = mcount + 1'b1;
          end
        end
      end
      mts_pkg::KIND_POP: begin
        if (ecount == '0) begin
          rsp_next.status = mts_pkg::ST_EMPTY;
        end else begin
          ecount_next           = ecount_dec;
          rsp_next.result_value = elem_rd;
          if ((mcount != '0) && (min_rd == elem_rd)) begin
            mcount_next = mcount_dec;
          end
        end
      end
      mts_pkg::KIND_MIN: begin
        if (mcount == '0) begin
          rsp_next.status = mts_pkg::ST_EMPTY;
        end else begin
          rsp_next.result_value = min_rd;
        end
      end
      default: begin
        rsp_next.status = mts_pkg::ST_OK;
      end
    endcase
  end

  // counts and response strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      ecount <= '0;
      mcount <= '0;
      done   <= 1'b0;
    end else begin
      done <= cmd.exec;
      if (cmd.exec) begin
        ecount <= ecount_next;
        mcount <= mcount_next;
      end
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

### src/mts_checker.sv
// ---------------------------------------------------------------------------
// mts_checker
// Port-level timing checks of the min tracking stack, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "min_tracking_stack_macros.svh"

module mts_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done,
  input wire mts_pkg::rsp_t rsp
);

  // accepted transaction makes the block busy next cycle
  `MTS_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  // every accepted transaction gets its response once its exec state is over
  `MTS_ASSERT_SAME(a_accept_done, clk, rst, start && !busy, ##2 done)
  // a response never shows while a transaction is in execution
  `MTS_ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  // responses never come back to back and never carry the reserved status
  `MTS_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `MTS_ASSERT_SAME(a_status_code, clk, rst, done, rsp.status != mts_pkg::ST_RSVD)

endmodule

bind min_tracking_stack mts_checker u_mts_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

`default_nettype wire

### bench/tb_min_tracking_stack.sv
// ---------------------------------------------------------------------------
// tb_min_tracking_stack
// Self-checking bench for the min tracking stack. Directed pushes, pops and
// minimum queries cover the empty and full stack, extreme and repeated
// values and the unused request kind. Random traffic follows under three
// start pacing profiles. Every response is compared with a shadow stack
// kept inside the bench.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_min_tracking_stack;

  // request kind the block leaves unused
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic signed [mts_pkg::DATA_W-1:0] VALUE_MAX =
    {1'b0, {(mts_pkg::DATA_W-1){1'b1}}};
  localparam logic signed [mts_pkg::DATA_W-1:0] VALUE_MIN =
    {1'b1, {(mts_pkg::DATA_W-1){1'b0}}};

  logic           clk   = 1'b0;
  logic           rst   = 1'b1;
  logic           start = 1'b0;
  logic           busy;
  mts_pkg::req_t  req   = '0;
  logic           done;
  mts_pkg::rsp_t  rsp;

  // shadow copy of the stack contents
  logic signed [mts_pkg::DATA_W-1:0] shadow_elems [mts_pkg::DEPTH];
  logic signed [mts_pkg::DATA_W-1:0] shadow_mins  [mts_pkg::DEPTH];
  int                                elem_cnt = 0;
  int                                min_cnt  = 0;

  mts_pkg::rsp_t predicted_replies [$];
  int            fail_count      = 0;
  int            sender_idle_pct = 0;

  min_tracking_stack dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop if the block hangs
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // apply one request to the shadow stack and return its response
  function automatic mts_pkg::rsp_t stack_reply_for(input mts_pkg::req_t r);
    mts_pkg::rsp_t                     reply;
    logic signed [mts_pkg::DATA_W-1:0] popped;
    reply.result_value = '0;
    reply.status       = mts_pkg::ST_OK;
    case (r.kind)
      mts_pkg::KIND_PUSH: begin
        if (elem_cnt >= mts_pkg::DEPTH) begin
          reply.status = mts_pkg::ST_FULL;
        end else begin
          shadow_elems[elem_cnt] = r.value;
          elem_cnt++;
          if (min_cnt == 0) begin
            shadow_mins[0] = r.value;
            min_cnt        = 1;
          end else if (min_cnt < mts_pkg::DEPTH && r.value <= shadow_mins[min_cnt-1]) begin
            shadow_mins[min_cnt] = r.value;
            min_cnt++;
          end
        end
      end
      mts_pkg::KIND_POP: begin
        if (elem_cnt == 0) begin
          reply.status = mts_pkg::ST_EMPTY;
        end else begin
          popped = shadow_elems[elem_cnt-1];
          elem_cnt--;
          if (min_cnt > 0 && shadow_mins[min_cnt-1] == popped) min_cnt--;
          reply.result_value = popped;
        end
      end
      mts_pkg::KIND_MIN: begin
        if (min_cnt == 0) reply.status = mts_pkg::ST_EMPTY;
        else reply.result_value = shadow_mins[min_cnt-1];
      end
      default: begin
        // unused kind: no state change, zero response
      end
    endcase
    return reply;
  endfunction

  // value mix: extremes, a narrow band around zero for repeats, full range
  function automatic logic signed [mts_pkg::DATA_W-1:0] random_value();
    int near_zero;
    near_zero = int'($urandom_range(8)) - 4;
    case ($urandom_range(9))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      2, 3, 4,
      5:       return mts_pkg::DATA_W'(near_zero);
      default: return mts_pkg::DATA_W'($urandom);
    endcase
  endfunction

  // drive one transaction and record its predicted response on acceptance
  task automatic issue_request(input logic [1:0] kind,
                               input logic signed [mts_pkg::DATA_W-1:0] value);
    mts_pkg::req_t r;
    r.kind  = kind;
    r.value = value;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted_replies.push_back(stack_reply_for(r));
  endtask

  // pop, query and unused kind on an empty stack
  task automatic test_empty_stack();
    issue_request(mts_pkg::KIND_POP, VALUE_MAX);
    issue_request(mts_pkg::KIND_MIN, VALUE_MIN);
    issue_request(KIND_UNUSED, -1);
  endtask

  // fill to capacity with extremes and repeats, overflow, then drain
  task automatic test_fill_and_drain();
    issue_request(mts_pkg::KIND_PUSH, VALUE_MAX);
    issue_request(mts_pkg::KIND_PUSH, 5);
    issue_request(mts_pkg::KIND_PUSH, 5);
    issue_request(mts_pkg::KIND_PUSH, -1);
    issue_request(mts_pkg::KIND_PUSH, VALUE_MIN);
    issue_request(mts_pkg::KIND_PUSH, VALUE_MIN);
    issue_request(mts_pkg::KIND_PUSH, 0);
    issue_request(mts_pkg::KIND_PUSH, VALUE_MAX);
    issue_request(mts_pkg::KIND_PUSH, 3);
    issue_request(mts_pkg::KIND_MIN, 0);
    issue_request(KIND_UNUSED, VALUE_MAX);
    for (int i = 0; i < mts_pkg::DEPTH; i++) begin
      issue_request(mts_pkg::KIND_POP, 0);
      if (i == 4) issue_request(mts_pkg::KIND_MIN, 0);
    end
    issue_request(mts_pkg::KIND_POP, -1);
  endtask

  // random request mix with a drifting push share so the stack swings
  // between empty and full
  task automatic test_random_traffic(input int idle_pct, input int n_items);
    int         push_share;
    int         pick;
    logic [1:0] kind;
    sender_idle_pct = idle_pct;
    push_share      = 45;
    for (int i = 0; i < n_items; i++) begin
      if (i % 16 == 0) push_share = 30 + 15 * int'($urandom_range(2));
      pick = $urandom_range(99);
      if (pick < push_share) kind = mts_pkg::KIND_PUSH;
      else if (pick < 80)    kind = mts_pkg::KIND_POP;
      else if (pick < 96)    kind = mts_pkg::KIND_MIN;
      else                   kind = KIND_UNUSED;
      issue_request(kind, random_value());
    end
  endtask

  // compare each response with the oldest prediction
  always @(posedge clk) begin
    mts_pkg::rsp_t want;
    if (!rst && done) begin
      if (predicted_replies.size() == 0) begin
        fail_count++;
        if (fail_count < 40)
          $display("%0t: unexpected response, expected none, actual value %0d status %0d",
                   $time, rsp.result_value, rsp.status);
      end else begin
        want = predicted_replies.pop_front();
        if (rsp.result_value !== want.result_value) begin
          fail_count++;
          if (fail_count < 40)
            $display("%0t: result_value mismatch, expected %0d, actual %0d",
                     $time, want.result_value, rsp.result_value);
        end
        if (rsp.status !== want.status) begin
          fail_count++;
          if (fail_count < 40)
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, rsp.status);
        end
      end
    end
  end

  // test sequence
  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    sender_idle_pct = 15;
    test_empty_stack();
    test_fill_and_drain();
    test_random_traffic(15, 570);
    test_random_traffic(55, 570);
    test_random_traffic(0, 570);

    @(negedge clk);
    start <= 1'b0;

    // let the last responses arrive, then watch for stray ones
    while (predicted_replies.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
